// ===== hdl/m3i_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_pkg: shared definitions for the 3x3 matrix inverse
// Default formats, element routing for the cofactor lanes and helpers.
// ----------------------------------------------------------------------------
package m3i_pkg;

    localparam int ELEMENT_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF     = 16;

    localparam int NUM_ELEM = 9;

    // Each adjugate entry is a*b - c*d. Indexes address the flattened matrix,
    // row times three plus column, in the order a, b, c, d.
    localparam int unsigned COF_SRC [NUM_ELEM][4] = '{
        '{4, 8, 7, 5},
        '{7, 2, 1, 8},
        '{1, 5, 4, 2},
        '{6, 5, 3, 8},
        '{0, 8, 6, 2},
        '{3, 2, 0, 5},
        '{3, 7, 6, 4},
        '{6, 1, 0, 7},
        '{0, 4, 3, 1}
    };

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/matrix3_inverse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// matrix3_inverse: 3x3 matrix inverse in signed fixed point
// Adjugate over determinant, rounded to nearest and saturated.
// ----------------------------------------------------------------------------
// Usage notes.
// One slave transaction carries a whole matrix, nine elements packed in
// s_tdata with row 0 column 0 in the lowest bits, row-major. One master
// transaction carries the inverse in the same layout in m_tdata, with
// m_tuser bit 0 as the singular flag and bit 1 as the saturation flag.
// The block is a single pipeline of ELEMENT_WIDTH+9 stages (41 at the
// default width): cofactor products, their difference, determinant partial
// products, their recombination, the determinant sum, divider set-up, one
// stage per quotient bit of the divider lanes (ELEMENT_WIDTH+1 of them),
// lane result and the output register. A new matrix can be taken every
// cycle when nothing stalls. The length is set by the bit-per-stage
// restoring divider in each of the nine lanes.
// Each stage moves on when it is empty or the stage after it moves, so a
// stalled receiver first lets the bubbles in the pipeline close and only
// then drops s_tready. A singular matrix yields the identity. Reset empties
// the pipeline; nothing else is held between transactions.
// ----------------------------------------------------------------------------
module matrix3_inverse
    import m3i_pkg::*;
#(
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
)
(
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     s_tvalid,
    output logic                                    s_tready,
    // in_00, in_01, in_02, in_10, in_11, in_12, in_20, in_21, in_22, zero fill
    input  wire logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                                    m_tvalid,
    input  wire                                     m_tready,
    // inv_00, inv_01, inv_02, inv_10, inv_11, inv_12, inv_20, inv_21, inv_22,
    // zero fill
    output logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0]    m_tdata,
    // singular, saturated
    output logic [1:0]                              m_tuser
);

    localparam int W   = ELEMENT_WIDTH;
    localparam int CW  = 2 * W + 1;
    localparam int DW  = 3 * W + 3;
    localparam int TDW = ((9 * W + 7) / 8) * 8;

    // Stage numbering along the pipeline.
    localparam int ST_PROD = 0;
    localparam int ST_DIFF = 1;
    localparam int ST_PREP = 5;
    localparam int ST_LANE = ST_PREP + W + 2;
    localparam int ST_OUT  = ST_LANE + 1;
    localparam int NS      = ST_OUT + 1;
    localparam int NZ      = ST_LANE - ST_PREP + 1;

    localparam logic [W-1:0] MAXPOS  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] ONE_VAL = (FRAC_BITS >= W - 1) ? MAXPOS : (W'(1) << FRAC_BITS);
    localparam logic         ONE_SAT = (FRAC_BITS >= W - 1);

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;

    logic signed [W-1:0]  elem    [NUM_ELEM];
    logic signed [CW-1:0] adj     [NUM_ELEM];
    logic signed [CW-1:0] adj_c_reg [NUM_ELEM];
    logic signed [CW-1:0] adj_d_reg [NUM_ELEM];
    logic signed [CW-1:0] adj_e_reg [NUM_ELEM];
    logic signed [W-1:0]  row0    [3];
    logic signed [CW-1:0] adj_col0 [3];
    logic signed [DW-1:0] det;

    logic signed [W-1:0] lane_value [NUM_ELEM];
    logic [NUM_ELEM-1:0] lane_sat;

    logic [NZ-1:0]  zero_reg;
    logic [TDW-1:0] data_reg;
    logic [1:0]     user_reg;
    logic [TDW-1:0] data_next;
    logic [1:0]     user_next;

    // Stage advance: a stage takes new contents when it is empty or drains.
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next = v_reg;
        for (int k = 0; k < NS; k++)
        begin
            if (en[k])
            begin
                v_next[k] = (k == 0) ? s_tvalid : v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign s_tready = en[0];

    for (genvar i = 0; i < NUM_ELEM; i++)
    begin : g_elem
        assign elem[i] = s_tdata[i*W +: W];
    end

    // Nine adjugate lanes.
    for (genvar i = 0; i < NUM_ELEM; i++)
    begin : g_cof
        m3i_cofactor #(
            .ELEMENT_WIDTH(ELEMENT_WIDTH)
        ) u_cof (
            .clk     (clk),
            .en_prod (en[ST_PROD]),
            .en_diff (en[ST_DIFF]),
            .a       (elem[COF_SRC[i][0]]),
            .b       (elem[COF_SRC[i][1]]),
            .c       (elem[COF_SRC[i][2]]),
            .d       (elem[COF_SRC[i][3]]),
            .adj     (adj[i])
        );
    end

    assign row0[0]     = elem[0];
    assign row0[1]     = elem[1];
    assign row0[2]     = elem[2];
    assign adj_col0[0] = adj[0];
    assign adj_col0[1] = adj[3];
    assign adj_col0[2] = adj[6];

    m3i_det #(
        .ELEMENT_WIDTH(ELEMENT_WIDTH)
    ) u_det (
        .clk      (clk),
        .en       (en[ST_PREP-1:ST_PROD]),
        .row0     (row0),
        .adj_col0 (adj_col0),
        .det      (det)
    );

    // The adjugate waits here while the determinant is being formed.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_ELEM; i++)
        begin
            if (en[ST_DIFF+1])
            begin
                adj_c_reg[i] <= adj[i];
            end
            if (en[ST_DIFF+2])
            begin
                adj_d_reg[i] <= adj_c_reg[i];
            end
            if (en[ST_DIFF+3])
            begin
                adj_e_reg[i] <= adj_d_reg[i];
            end
        end
    end

    for (genvar i = 0; i < NUM_ELEM; i++)
    begin : g_div
        m3i_div_lane #(
            .ELEMENT_WIDTH(ELEMENT_WIDTH),
            .FRAC_BITS    (FRAC_BITS)
        ) u_div (
            .clk   (clk),
            .en    (en[ST_LANE:ST_PREP]),
            .adj   (adj_e_reg[i]),
            .det   (det),
            .value (lane_value[i]),
            .sat   (lane_sat[i])
        );
    end

    // The zero-determinant flag travels beside the divider lanes.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NZ; k++)
        begin
            if (en[ST_PREP+k])
            begin
                zero_reg[k] <= (k == 0) ? (det == '0) : zero_reg[k-1];
            end
        end
    end

    // Merge: identity for a singular matrix, otherwise the lane results.
    always_comb
    begin
        data_next = '0;
        if (zero_reg[NZ-1])
        begin
            data_next[0*W +: W] = ONE_VAL;
            data_next[4*W +: W] = ONE_VAL;
            data_next[8*W +: W] = ONE_VAL;
            user_next = {ONE_SAT, 1'b1};
        end
        else
        begin
            for (int i = 0; i < NUM_ELEM; i++)
            begin
                data_next[i*W +: W] = lane_value[i];
            end
            user_next = {|lane_sat, 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            data_reg <= data_next;
            user_reg <= user_next;
        end
    end

    assign m_tvalid = v_reg[ST_OUT];
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule
`default_nettype wire

// ===== hdl/m3i_cofactor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_cofactor: one adjugate lane
// Two registered products, then their registered difference.
// ----------------------------------------------------------------------------
module m3i_cofactor
    import m3i_pkg::*;
#(
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
)
(
    input  wire                                  clk,
    input  wire                                  en_prod,
    input  wire                                  en_diff,
    input  wire logic signed [ELEMENT_WIDTH-1:0] a,
    input  wire logic signed [ELEMENT_WIDTH-1:0] b,
    input  wire logic signed [ELEMENT_WIDTH-1:0] c,
    input  wire logic signed [ELEMENT_WIDTH-1:0] d,
    output logic signed [2*ELEMENT_WIDTH:0]      adj
);

    localparam int PW = 2 * ELEMENT_WIDTH;

    logic signed [PW-1:0] p_reg;
    logic signed [PW-1:0] q_reg;
    logic signed [PW:0]   adj_reg;

    always_ff @(posedge clk)
    begin
        if (en_prod)
        begin
            p_reg <= a * b;
            q_reg <= c * d;
        end
        if (en_diff)
        begin
            adj_reg <= (PW+1)'(p_reg) - (PW+1)'(q_reg);
        end
    end

    assign adj = adj_reg;

endmodule
`default_nettype wire

// ===== hdl/m3i_det.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_det: determinant from row 0 against the adjugate's column 0
// Each wide product is split into two narrow partial products.
// ----------------------------------------------------------------------------
module m3i_det
    import m3i_pkg::*;
#(
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
)
(
    input  wire                                  clk,
    input  wire logic [4:0]                      en,
    input  wire logic signed [ELEMENT_WIDTH-1:0] row0 [3],
    input  wire logic signed [2*ELEMENT_WIDTH:0] adj_col0 [3],
    output logic signed [3*ELEMENT_WIDTH+2:0]    det
);

    localparam int W  = ELEMENT_WIDTH;
    localparam int CW = 2 * W + 1;
    localparam int DW = 3 * W + 3;

    logic signed [W-1:0]  e_a_reg [3];
    logic signed [W-1:0]  e_b_reg [3];
    logic signed [2*W:0]  lo_reg [3];
    logic signed [2*W:0]  hi_reg [3];
    logic signed [DW-1:0] prod_reg [3];
    logic signed [DW-1:0] det_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (en[0])
            begin
                e_a_reg[i] <= row0[i];
            end
            if (en[1])
            begin
                e_b_reg[i] <= e_a_reg[i];
            end
            if (en[2])
            begin
                lo_reg[i] <= e_b_reg[i] * $signed({1'b0, adj_col0[i][W-1:0]});
                hi_reg[i] <= e_b_reg[i] * $signed(adj_col0[i][CW-1:W]);
            end
            if (en[3])
            begin
                prod_reg[i] <= (DW'(hi_reg[i]) <<< W) + DW'(lo_reg[i]);
            end
        end
        if (en[4])
        begin
            det_reg <= prod_reg[0] + prod_reg[1] + prod_reg[2];
        end
    end

    assign det = det_reg;

endmodule
`default_nettype wire

// ===== hdl/m3i_div_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_div_lane: rounded, saturated quotient of one adjugate entry
// Restoring division, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module m3i_div_lane
    import m3i_pkg::*;
#(
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
)
(
    input  wire                                  clk,
    input  wire logic [ELEMENT_WIDTH+2:0]        en,
    input  wire logic signed [2*ELEMENT_WIDTH:0] adj,
    input  wire logic signed [3*ELEMENT_WIDTH+2:0] det,
    output logic signed [ELEMENT_WIDTH-1:0]      value,
    output logic                                 sat
);

    localparam int W  = ELEMENT_WIDTH;
    localparam int CW = 2 * W + 1;
    localparam int DW = 3 * W + 3;
    localparam int NW = max_int(CW + 2 * FRAC_BITS + 1, DW) + 1;
    localparam int XW = max_int(NW, DW + 1 + W);
    localparam int QW = W + 1;
    localparam int NSTEP = W + 1;

    localparam logic [QW-1:0] LIM_POS = QW'({1'b0, {(W-1){1'b1}}});
    localparam logic [QW-1:0] LIM_NEG = QW'(1) << (W - 1);

    logic [CW-1:0] adj_mag;
    logic [DW-1:0] det_mag;

    logic [XW-1:0] rem_reg [NSTEP+1];
    logic [DW:0]   den_reg [NSTEP+1];
    logic [QW-1:0] q_reg   [NSTEP+1];
    logic          neg_reg [NSTEP+1];

    logic signed [W-1:0] value_reg;
    logic                sat_reg;
    logic [QW-1:0]       limit;
    logic                over;
    logic [QW-1:0]       mag;

    assign adj_mag = adj[CW-1] ? CW'(-adj) : CW'(adj);
    assign det_mag = det[DW-1] ? DW'(-det) : DW'(det);

    // Numerator 2|A|*2^(2F) + |D|, denominator 2|D|: floor gives round half away.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= (XW'(adj_mag) << (2 * FRAC_BITS + 1)) + XW'(det_mag);
            den_reg[0] <= (DW+1)'(det_mag) << 1;
            q_reg[0]   <= '0;
            neg_reg[0] <= adj[CW-1] ^ det[DW-1];
        end
    end

    for (genvar s = 1; s <= NSTEP; s++)
    begin : g_step
        localparam int B = NSTEP - s;
        logic [XW-1:0] shifted;
        logic          ge;
        logic [QW-1:0] q_next;

        assign shifted = XW'(den_reg[s-1]) << B;
        assign ge      = (rem_reg[s-1] >= shifted);
        assign q_next  = q_reg[s-1] | (QW'(ge) << B);

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                rem_reg[s]    <= ge ? (rem_reg[s-1] - shifted) : rem_reg[s-1];
                den_reg[s]    <= den_reg[s-1];
                neg_reg[s]    <= neg_reg[s-1];
                q_reg[s]      <= q_next;
            end
        end
    end

    // A quotient of 2^W or more shows up as the top bit and always saturates.
    assign limit = neg_reg[NSTEP] ? LIM_NEG : LIM_POS;
    assign over  = (q_reg[NSTEP] > limit);
    assign mag   = over ? limit : q_reg[NSTEP];

    always_ff @(posedge clk)
    begin
        if (en[NSTEP+1])
        begin
            value_reg <= neg_reg[NSTEP] ? W'(~mag + QW'(1)) : W'(mag);
            sat_reg   <= over;
        end
    end

    assign value = value_reg;
    assign sat   = sat_reg;

endmodule
`default_nettype wire

// ===== hdl/m3i_check.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_check: port-level checks for the 3x3 matrix inverse
// Watches the top level's ports and is attached by a bind statement.
// ----------------------------------------------------------------------------
module m3i_check
    import m3i_pkg::*;
#(
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
)
(
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     s_tready,
    input  wire                                     m_tvalid,
    input  wire                                     m_tready,
    input  wire logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0] m_tdata,
    input  wire logic [1:0]                         m_tuser
);

    localparam int W = ELEMENT_WIDTH;
    localparam logic [W-1:0] MAXPOS  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] ONE_VAL = (FRAC_BITS >= W - 1) ? MAXPOS : (W'(1) << FRAC_BITS);
    localparam logic         ONE_SAT = (FRAC_BITS >= W - 1);

    // Reset empties the pipeline, so nothing is offered during reset.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result offered during reset");

    // With the output stage empty every stage can move, so input is taken.
    a_ready_when_empty: assert property (@(posedge clk) !m_tvalid |-> s_tready)
        else $error("input stalled while the output stage is empty");

    // A result waiting for the receiver must not change.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A singular result is the identity matrix.
    a_identity: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            m_tdata[0*W +: W] == ONE_VAL && m_tdata[4*W +: W] == ONE_VAL &&
            m_tdata[8*W +: W] == ONE_VAL && m_tdata[1*W +: W] == '0 &&
            m_tdata[2*W +: W] == '0 && m_tdata[3*W +: W] == '0 &&
            m_tdata[5*W +: W] == '0 && m_tdata[6*W +: W] == '0 &&
            m_tdata[7*W +: W] == '0)
        else $error("singular result is not the identity");

    // For a singular result the saturation flag only tells whether one fits.
    a_singular_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tuser[1] == ONE_SAT)
        else $error("wrong saturation flag on singular result");

endmodule

bind matrix3_inverse m3i_check #(
    .ELEMENT_WIDTH(ELEMENT_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
) u_m3i_check (.*);
`default_nettype wire
